### rtl/lfu_cache_table_defines.svh
// ----------------------------------------------------------------------------
// LFU cache table assertion macros
// Shared concurrent assertion forms used by the cache table RTL. They expect
// clk_i and rst_ni to be visible where they are used.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_TABLE_DEFINES_SVH
`define LFU_CACHE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lct_pkg.sv
// ----------------------------------------------------------------------------
// LFU cache table package
// Field widths, operation codes and the request and response word types.
// ----------------------------------------------------------------------------
`default_nettype none

package lct_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  // Capacity register value after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } func_e;

  typedef struct packed {
    func_e                   func;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
    logic [KEY_W-1:0]        evicted_key;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/lct_lookup.sv
// ----------------------------------------------------------------------------
// LFU cache table key lookup
// Compares the request key against every valid entry in parallel and
// returns the hit flag and the index of the matching entry.
// ----------------------------------------------------------------------------
`default_nettype none

module lct_lookup import lct_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = 4
) (
  input  logic [ENTRIES-1:0]            valid_i,
  input  logic [ENTRIES-1:0][KEY_W-1:0] key_i,
  input  logic [KEY_W-1:0]              lookup_key_i,
  output logic                          hit_o,
  output logic [IDX_W-1:0]              idx_o
);

  logic [ENTRIES-1:0] match;

  // One comparator per entry.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_i[i] && (key_i[i] == lookup_key_i);
    end
  end

  // Keys are unique among valid entries, so at most one match is set and the
  // index can be formed by OR-ing the masked entry numbers.
  always_comb begin
    idx_o = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        idx_o = idx_o | IDX_W'(i);
      end
    end
  end

  assign hit_o = |match;

endmodule

`default_nettype wire

### rtl/lct_victim_sel.sv
// ----------------------------------------------------------------------------
// LFU cache table victim selection
// Balanced comparison tree that finds the valid entry with the lowest use
// count, taking the least recently touched one among equal counts.
// ----------------------------------------------------------------------------
`default_nettype none

module lct_victim_sel #(
  parameter int ENTRIES    = 16,
  parameter int IDX_W      = 4,
  parameter int COUNT_BITS = 16
) (
  input  logic [ENTRIES-1:0]                 valid_i,
  input  logic [ENTRIES-1:0][COUNT_BITS-1:0] count_i,
  input  logic [ENTRIES-1:0][IDX_W-1:0]      rank_i,
  output logic                               any_o,
  output logic [IDX_W-1:0]                   idx_o
);

  localparam int LEVELS = (ENTRIES > 1) ? $clog2(ENTRIES) : 0;
  localparam int LEAVES = 1 << LEVELS;
  localparam int NODES  = 2 * LEAVES - 1;

  // Heap-ordered tree: node n has children 2n+1 and 2n+2, leaves at the end.
  logic                  node_any  [NODES];
  logic [COUNT_BITS-1:0] node_cnt  [NODES];
  logic [IDX_W-1:0]      node_rank [NODES];
  logic [IDX_W-1:0]      node_idx  [NODES];

  // Leaves; padding leaves never win.
  for (genvar l = 0; l < LEAVES; l++) begin : g_leaf
    if (l < ENTRIES) begin : g_real
      assign node_any[LEAVES-1+l]  = valid_i[l];
      assign node_cnt[LEAVES-1+l]  = count_i[l];
      assign node_rank[LEAVES-1+l] = rank_i[l];
      assign node_idx[LEAVES-1+l]  = IDX_W'(l);
    end else begin : g_pad
      assign node_any[LEAVES-1+l]  = 1'b0;
      assign node_cnt[LEAVES-1+l]  = '0;
      assign node_rank[LEAVES-1+l] = '0;
      assign node_idx[LEAVES-1+l]  = '0;
    end
  end

  // Inner nodes: the right child wins with a lower count, or an equal count
  // and an older recency rank.
  for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
    logic take_r;
    assign take_r = node_any[2*n+2] &&
                    (!node_any[2*n+1] ||
                     (node_cnt[2*n+2] < node_cnt[2*n+1]) ||
                     ((node_cnt[2*n+2] == node_cnt[2*n+1]) &&
                      (node_rank[2*n+2] > node_rank[2*n+1])));
    assign node_any[n]  = node_any[2*n+1] | node_any[2*n+2];
    assign node_cnt[n]  = take_r ? node_cnt[2*n+2]  : node_cnt[2*n+1];
    assign node_rank[n] = take_r ? node_rank[2*n+2] : node_rank[2*n+1];
    assign node_idx[n]  = take_r ? node_idx[2*n+2]  : node_idx[2*n+1];
  end

  assign any_o = node_any[0];
  assign idx_o = node_idx[0];

endmodule

`default_nettype wire

### rtl/lfu_cache_table.sv
// ----------------------------------------------------------------------------
// LFU cache table
// Fully associative key/value store with least-frequently-used replacement
// and least-recently-used tie break.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive as req_t words on req_valid_i/req_ready_o; each carries a
// get or a put with a key and a value. Every request yields exactly one
// rsp_t word on rsp_valid_o/rsp_ready_i: the hit flag, the value read on a
// get hit, and the key of any entry a put evicted.
// The capacity register is written through cfg_valid_i/cfg_data_i, which is
// always ready; it should only be written while no request is in flight.
// A request is captured in an input register and, once the response
// register is free or being emptied, the lookup, victim search and table
// update are done in one pass into the response register, which then
// offers the response word. One request is taken every cycle while the
// receiver keeps rsp_ready_i high; the figure is set by the update pass
// through the key comparators and the victim tree.
// When the receiver stalls, the response register holds its word and one
// more request may wait in the input register before req_ready_o falls.
// Reset empties the table, clears the occupancy and sets the capacity to 16.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lfu_cache_table_defines.svh"

module lfu_cache_table import lct_pkg::*; #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_data_i,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  req_t             req_i,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output rsp_t             rsp_o
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Configuration.
  logic [CAP_W-1:0] cap_q;
  logic [OCC_W-1:0] cap_eff;

  // Input and response registers.
  req_t req_q;
  logic req_vld_q;
  rsp_t rsp_q, rsp_d;
  logic rsp_vld_q;
  logic fire;

  // Entry table.
  logic [ENTRIES-1:0]                 valid_q, valid_d;
  logic [ENTRIES-1:0][KEY_W-1:0]      key_q;
  logic [ENTRIES-1:0][VAL_W-1:0]      val_q;
  logic [ENTRIES-1:0][COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [ENTRIES-1:0][IDX_W-1:0]      rank_q, rank_d;
  logic [ENTRIES-1:0]                 key_we, val_we;
  logic [OCC_W-1:0]                   occ_q, occ_d;

  // Decision signals.
  logic             hit, vic_any, free_any;
  logic [IDX_W-1:0] hit_idx, vic_idx, free_idx, slot;
  logic [IDX_W-1:0] hit_rank, vic_rank;
  logic             is_put, cap_nz, full;
  logic             do_bump, do_ins, do_evict, do_fill;

  // Configuration port is always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // Capacity above the table size acts as the table size.
  always_comb begin
    if (32'(cap_q) > ENTRIES) begin
      cap_eff = OCC_W'(ENTRIES);
    end else begin
      cap_eff = OCC_W'(cap_q);
    end
  end

  // Handshake: the input register moves on whenever its word is processed.
  assign fire        = req_vld_q && (!rsp_vld_q || rsp_ready_i);
  assign req_ready_o = !req_vld_q || fire;
  assign rsp_valid_o = rsp_vld_q;
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      if (req_ready_o) begin
        req_vld_q <= req_valid_i;
      end
      if (fire) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_ready_o && req_valid_i) begin
      req_q <= req_i;
    end
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  // Key lookup and victim search.
  lct_lookup #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_lookup (
    .valid_i      (valid_q),
    .key_i        (key_q),
    .lookup_key_i (req_q.key),
    .hit_o        (hit),
    .idx_o        (hit_idx)
  );

  lct_victim_sel #(
    .ENTRIES    (ENTRIES),
    .IDX_W      (IDX_W),
    .COUNT_BITS (COUNT_BITS)
  ) u_victim (
    .valid_i (valid_q),
    .count_i (cnt_q),
    .rank_i  (rank_q),
    .any_o   (vic_any),
    .idx_o   (vic_idx)
  );

  // Lowest free entry for a fill without eviction.
  always_comb begin
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign free_any = ~&valid_q;

  // Request decode.
  assign is_put   = (req_q.func == FUNC_PUT);
  assign cap_nz   = (cap_eff != '0);
  assign full     = (occ_q >= cap_eff);
  assign do_bump  = hit && (!is_put || cap_nz);
  assign do_ins   = is_put && cap_nz && !hit;
  assign do_evict = do_ins && full && vic_any;
  assign do_fill  = do_ins && (do_evict || free_any);
  assign slot     = do_evict ? vic_idx : free_idx;
  assign hit_rank = rank_q[hit_idx];
  assign vic_rank = rank_q[vic_idx];

  // Per-entry next state.
  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    rank_d  = rank_q;
    key_we  = '0;
    val_we  = '0;
    occ_d   = occ_q;
    if (fire) begin
      if (do_bump) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IDX_W'(i) == hit_idx) begin
            if (cnt_q[i] != COUNT_MAX) begin
              cnt_d[i] = cnt_q[i] + COUNT_BITS'(1);
            end
            rank_d[i] = '0;
            val_we[i] = is_put;
          end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
            rank_d[i] = rank_q[i] + IDX_W'(1);
          end
        end
      end else if (do_fill) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IDX_W'(i) == slot) begin
            valid_d[i] = 1'b1;
            cnt_d[i]   = COUNT_BITS'(1);
            rank_d[i]  = '0;
            key_we[i]  = 1'b1;
            val_we[i]  = 1'b1;
          end else if (valid_q[i]) begin
            // Entries older than the victim close its gap, then all age by one.
            if (do_evict && (rank_q[i] > vic_rank)) begin
              rank_d[i] = rank_q[i];
            end else begin
              rank_d[i] = rank_q[i] + IDX_W'(1);
            end
          end
        end
        if (!do_evict) begin
          occ_d = occ_q + OCC_W'(1);
        end
      end
    end
  end

  // Control state of the table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cnt_q   <= '0;
      rank_q  <= '0;
      occ_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      rank_q  <= rank_d;
      occ_q   <= occ_d;
    end
  end

  // Key and value storage.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (key_we[i]) begin
        key_q[i] <= req_q.key;
      end
      if (val_we[i]) begin
        val_q[i] <= req_q.value;
      end
    end
  end

  // Response word.
  always_comb begin
    rsp_d.hit         = hit;
    rsp_d.read_value  = (hit && !is_put) ? $signed(val_q[hit_idx]) : '0;
    rsp_d.evicted     = do_evict;
    rsp_d.evicted_key = do_evict ? key_q[vic_idx] : '0;
  end

  // Assertions.
  `LCT_ASSERT_IMP(a_occ_matches_valid, 1'b1, 32'(occ_q) == $countones(valid_q), "occupancy differs from the number of valid entries")
  `LCT_ASSERT_IMP(a_evict_only_on_miss, rsp_vld_q && rsp_q.evicted, !rsp_q.hit, "eviction reported for a request that hit")
  `LCT_ASSERT_NXT(a_get_miss_keeps_table, fire && !is_put && !hit, $stable(valid_q) && $stable(occ_q), "get miss changed the table")

endmodule

`default_nettype wire

### sim/lfu_cache_table_tb.sv
// ----------------------------------------------------------------------------
// LFU cache table testbench
// Drives get and put requests into the cache table and checks every response
// word against a behavioural model of the table, which keeps its own entries,
// use counts and recency order. A directed opening covers field extremes, the
// zero capacity, lowered capacity and equal use counts settled by recency.
// Random phases at several capacities follow, with random idling on both
// sides and one long receiver stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfu_cache_table_tb;
  import lct_pkg::*;

  localparam int N           = 16;
  localparam int CNT_W       = 16;
  localparam int IDLE_PCT    = 13;
  localparam int HOLD_CYCLES = 64;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 50;
  localparam int POOL_SIZE   = 22;
  localparam int TIE_ROUNDS  = 4;

  // Model of the table: predicts one response word per accepted request.
  class lfu_scoreboard;
    bit                      used [N];
    logic [KEY_W-1:0]        tag [N];
    logic signed [VAL_W-1:0] data [N];
    logic [CNT_W-1:0]        uses [N];
    logic [3:0]              age [N];
    logic [CAP_W-1:0]        occupied;
    logic [CAP_W-1:0]        capacity;
    rsp_t                    expected_rsp [$];
    int                      mismatches;

    function new();
      foreach (used[i]) used[i] = 1'b0;
      occupied   = '0;
      capacity   = CAP_RESET;
      mismatches = 0;
    endfunction

    // Age every entry younger than idx by one and make idx the youngest.
    function void make_newest(int idx);
      logic [3:0] old;
      old = age[idx];
      for (int i = 0; i < N; i++)
        if (used[i] && i != idx && age[i] < old) age[i]++;
      age[idx] = '0;
    endfunction

    function void count_use(int idx);
      if (uses[idx] != '1) uses[idx]++;
      make_newest(idx);
    endfunction

    function void note_request(req_t r);
      rsp_t             want;
      int               found;
      int               slot;
      int               victim;
      logic [CAP_W-1:0] cap;
      want  = '0;
      cap   = (capacity > CAP_W'(N)) ? CAP_W'(N) : capacity;
      found = -1;
      for (int i = 0; i < N; i++)
        if (found < 0 && used[i] && tag[i] == r.key) found = i;
      want.hit = (found >= 0);
      if (r.func == FUNC_GET) begin
        if (found >= 0) begin
          want.read_value = data[found];
          count_use(found);
        end
      end else if (cap != '0) begin
        if (found >= 0) begin
          data[found] = r.value;
          count_use(found);
        end else begin
          slot = -1;
          // A full table gives up its least used entry, the oldest on a tie.
          if (occupied >= cap) begin
            victim = -1;
            for (int i = 0; i < N; i++)
              if (used[i] && (victim < 0 || uses[i] < uses[victim] ||
                  (uses[i] == uses[victim] && age[i] > age[victim])))
                victim = i;
            if (victim >= 0) begin
              for (int i = 0; i < N; i++)
                if (used[i] && age[i] > age[victim]) age[i]--;
              used[victim]       = 1'b0;
              occupied           = occupied - 1'b1;
              want.evicted       = 1'b1;
              want.evicted_key   = tag[victim];
              slot               = victim;
            end
          end
          if (slot < 0)
            for (int i = 0; i < N; i++)
              if (slot < 0 && !used[i]) slot = i;
          if (slot >= 0) begin
            for (int i = 0; i < N; i++)
              if (used[i]) age[i]++;
            used[slot] = 1'b1;
            tag[slot]  = r.key;
            data[slot] = r.value;
            uses[slot] = CNT_W'(1);
            age[slot]  = '0;
            occupied   = occupied + 1'b1;
          end
        end
      end
      expected_rsp = {expected_rsp, want};
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_rsp.size() == 0) begin
        $error("response word with no request outstanding");
        mismatches++;
        return;
      end
      want = expected_rsp[0];
      expected_rsp.delete(0);
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, got.hit);
        mismatches++;
      end
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
        mismatches++;
      end
      if (got.evicted !== want.evicted) begin
        $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
        mismatches++;
      end
      if (got.evicted_key !== want.evicted_key) begin
        $error("evicted_key: expected %h, got %h", want.evicted_key, got.evicted_key);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CAP_W-1:0] cfg_data_i;
  logic             req_valid_i;
  logic             req_ready_o;
  req_t             req_i;
  logic             rsp_valid_o;
  logic             rsp_ready_i;
  rsp_t             rsp_o;

  lfu_scoreboard    board;
  bit               no_idle;
  bit               stall_sink;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  logic [CAP_W-1:0] phase_cap [PHASES] = '{16, 4, 0, 31, 1, 9, 16, 2, 17, 5};

  lfu_cache_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one request word, idling first at random, and log it once taken.
  task automatic send_request(input func_e f, input logic [KEY_W-1:0] k,
                              input logic signed [VAL_W-1:0] v);
    req_t r;
    r.func  = f;
    r.key   = k;
    r.value = v;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= r;
    do @(posedge clk_i); while (!req_ready_o);
    board.note_request(r);
  endtask

  // Stop offering and wait until every response has come back.
  task automatic settle();
    req_valid_i <= 1'b0;
    while (board.expected_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.capacity = cap;
    cfg_valid_i <= 1'b0;
  endtask

  // Response side: random back-pressure, plus one long hold-off on request.
  initial begin : sink
    rsp_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_sink) begin
        stall_sink = 1'b0;
        rsp_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      rsp_ready_i <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Every response word taken is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && rsp_ready_i) board.check_response(rsp_o);
  end

  // Give up when nothing has moved on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int                      span;
    func_e                   f;
    logic [KEY_W-1:0]        k;
    logic signed [VAL_W-1:0] v;
    board       = new();
    no_idle     = 1'b0;
    stall_sink  = 1'b0;
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    req_valid_i <= 1'b0;
    req_i       <= '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table, field extremes, overwrite on hit, and a stored minus one.
    send_request(FUNC_GET, 32'h0000_0000, 32'sh0);
    send_request(FUNC_PUT, 32'h0000_0000, 32'sh7FFF_FFFF);
    send_request(FUNC_PUT, 32'hFFFF_FFFF, 32'sh8000_0000);
    send_request(FUNC_GET, 32'h0000_0000, 32'sh0);
    send_request(FUNC_GET, 32'hFFFF_FFFF, 32'sh0);
    send_request(FUNC_PUT, 32'h0000_0000, -32'sd1);
    send_request(FUNC_GET, 32'h0000_0000, 32'sh1234_5678);
    send_request(FUNC_GET, 32'h0000_0001, 32'sh0);

    // With no capacity a put changes nothing, but presence is still seen.
    write_capacity(5'd0);
    send_request(FUNC_PUT, 32'h0000_0002, 32'sd5);
    send_request(FUNC_PUT, 32'h0000_0000, 32'sd7);
    send_request(FUNC_GET, 32'h0000_0000, 32'sh0);

    // Capacity lowered to the occupancy: a miss evicts and then fills.
    write_capacity(5'd2);
    send_request(FUNC_PUT, 32'h0000_0003, 32'sd3);
    send_request(FUNC_GET, 32'h0000_0002, 32'sh0);
    send_request(FUNC_GET, 32'hFFFF_FFFF, 32'sh0);

    // Bring both entries to the same use count, raise them together, then
    // let a miss pick between the two equal counts by recency.
    repeat (4) send_request(FUNC_GET, 32'h0000_0003, 32'sh0);
    for (int n = 0; n < TIE_ROUNDS; n++) begin
      send_request(FUNC_GET, 32'h0000_0000, 32'sh0);
      send_request(FUNC_GET, 32'h0000_0003, 32'sh0);
    end
    send_request(FUNC_PUT, 32'h0000_0009, 32'sd9);
    send_request(FUNC_GET, 32'h0000_0003, 32'sh0);
    send_request(FUNC_PUT, 32'h0000_000A, 32'sd10);

    // Random phases: keys mostly from a pool a little larger than the
    // capacity so that hits and evictions are both frequent.
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_cap[p]);
      span    = ((phase_cap[p] > 5'd16) ? 16 : int'(phase_cap[p])) + 6;
      no_idle = (p == 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 0 && n == 20) stall_sink = 1'b1;
        f = ($urandom_range(1) == 1) ? FUNC_PUT : FUNC_GET;
        k = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(span - 1)];
        case ($urandom_range(7))
          0:       v = 32'sh7FFF_FFFF;
          1:       v = 32'sh8000_0000;
          2:       v = -32'sd1;
          default: v = $signed($urandom);
        endcase
        send_request(f, k, v);
      end
    end
    no_idle = 1'b0;

    settle();
    if (board.mismatches == 0 && board.expected_rsp.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
